FILE: sv/homogeneous_vertex_transform_core_defines.svh
// Assertion macros for the homogeneous vertex transform core.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform core.
// No dependencies; imported by every module of the block.
package hvt_pkg;

	// Q16.16 one.
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

	// Configuration register indexes.
	localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
	localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
	localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;
	localparam int NUM_REGS = 8;

	// Reset values: the identity matrix.
	localparam logic [63:0] DIAG_LO = 64'h0000_0000_0001_0000;
	localparam logic [63:0] DIAG_HI = 64'h0001_0000_0000_0000;

	// Divider: magnitude of (component * 65536) needs 48 bits.
	localparam int DIV_BITS = 48;

	// Four 32-bit components packed together.
	typedef logic [3:0][31:0] vec4_t;

	// Side data that travels alongside the divider lanes.
	typedef struct packed {
		logic             divq;
		logic             sat;
		logic [2:0]       neg;
		logic [2:0][31:0] raw;
		logic [31:0]      w;
	} side_t;

	// Magnitude of a signed 32-bit value; -2^31 maps to 2^31.
	function automatic logic [31:0] abs32(input logic [31:0] v);
		abs32 = v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

FILE: sv/homogeneous_vertex_transform_core.sv
// Homogeneous vertex transform: 4x4 Q16.16 matrix times vertex, then
// perspective divide of x, y, z by the transformed w.
//
// Input channel: in_valid/in_stall with in_x, in_y, in_z, in_w (signed Q16.16).
// Output channel: out_valid/out_stall with out_x, out_y, out_z, out_w,
// divided and saturated. A beat moves when valid is high and stall is low.
// Configuration: cfg_we writes cfg_data into matrix register cfg_index;
// rows are held as two 64-bit registers of two columns each.
// Write the matrix only while no vertex is in flight.
//
// The row dot products pass through multiply, two adds, and round and
// clamp; the divider resolves one quotient bit per stage; the output
// register follows. One vertex is taken every cycle unless the pipeline stalls.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity matrix.
module homogeneous_vertex_transform_core import hvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] in_x,
	input  logic [31:0] in_y,
	input  logic [31:0] in_z,
	input  logic [31:0] in_w,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_w,
	output logic        divided,
	output logic        saturated,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]         mat_q [NUM_REGS];
	logic                en;
	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic                vld_d [DIV_BITS];
	side_t               side_d [DIV_BITS];
	side_t               side_in;
	vec4_t               vec;
	logic [3:0][31:0]    dot;
	logic [3:0]          dot_sat;
	logic [2:0][DIV_BITS-1:0] quo;
	logic [2:0][31:0]    fin_val;
	logic [2:0]          fin_sat;
	logic [31:0]         w_mag;
	logic                out_valid_q;
	logic [2:0][31:0]    res_q;
	logic [31:0]         w_q;
	logic                div_q, sat_q;

	// The pipeline moves unless a finished result is held by the receiver.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[REG_ROW0_COLS01] <= DIAG_LO;
			mat_q[REG_ROW0_COLS23] <= '0;
			mat_q[REG_ROW1_COLS01] <= DIAG_HI;
			mat_q[REG_ROW1_COLS23] <= '0;
			mat_q[REG_ROW2_COLS01] <= '0;
			mat_q[REG_ROW2_COLS23] <= DIAG_LO;
			mat_q[REG_ROW3_COLS01] <= '0;
			mat_q[REG_ROW3_COLS23] <= DIAG_HI;
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	assign vec = {in_w, in_z, in_y, in_x};

	// One dot product unit per matrix row.
	for (genvar r = 0; r < 4; r++) begin : g_row
		vec4_t row;
		for (genvar c = 0; c < 4; c++) begin : g_col
			assign row[c] = mat_q[r*2 + c/2][(c%2)*32 +: 32];
		end
		hvt_row u_row (
			.clk (clk),
			.en  (en),
			.row (row),
			.vec (vec),
			.res (dot[r]),
			.sat (dot_sat[r])
		);
	end

	// Valid bits for the dot product stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Divide decision and the data that rides beside the divider.
	always_comb begin
		side_in.divq = (dot[3] != 32'd0) && (dot[3] != Q_ONE);
		side_in.sat  = |dot_sat;
		side_in.w    = dot[3];
		for (int i = 0; i < 3; i++) begin
			side_in.neg[i] = dot[i][31] ^ dot[3][31];
			side_in.raw[i] = dot[i];
		end
	end

	assign w_mag = abs32(dot[3]);

	for (genvar i = 0; i < 3; i++) begin : g_div
		hvt_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend ({abs32(dot[i]), 16'd0}),
			.divisor  (w_mag),
			.quotient (quo[i])
		);
	end

	// Side data pipeline, one entry per divider stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_BITS; j++) begin
				vld_d[j] <= 1'b0;
			end
		end else if (en) begin
			vld_d[0] <= vld_s4;
			for (int j = 1; j < DIV_BITS; j++) begin
				vld_d[j] <= vld_d[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_in;
			for (int j = 1; j < DIV_BITS; j++) begin
				side_d[j] <= side_d[j-1];
			end
		end
	end

	// Apply the quotient sign and clamp to 32 bits, or pass the raw dot product when no divide is taken.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fin_sat[i] = 1'b0;
			if (!side_d[DIV_BITS-1].divq) begin
				fin_val[i] = side_d[DIV_BITS-1].raw[i];
			end else if (side_d[DIV_BITS-1].neg[i]) begin
				if (quo[i] > 48'h0000_8000_0000) begin
					fin_val[i] = 32'h8000_0000;
					fin_sat[i] = 1'b1;
				end else begin
					fin_val[i] = ~quo[i][31:0] + 32'd1;
				end
			end else begin
				if (quo[i] > 48'h0000_7FFF_FFFF) begin
					fin_val[i] = 32'h7FFF_FFFF;
					fin_sat[i] = 1'b1;
				end else begin
					fin_val[i] = quo[i][31:0];
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_d[DIV_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fin_val;
			w_q   <= side_d[DIV_BITS-1].w;
			div_q <= side_d[DIV_BITS-1].divq;
			sat_q <= side_d[DIV_BITS-1].sat | (|fin_sat);
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign out_w     = w_q;
	assign divided   = div_q;
	assign saturated = sat_q;

endmodule

FILE: sv/hvt_row.sv
// One matrix row dot product: multiply, two add stages, round and clamp.
// Depends on hvt_pkg. Four register stages, advanced by en.
module hvt_row import hvt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  vec4_t       row,
	input  vec4_t       vec,
	output logic [31:0] res,
	output logic        sat
);

	logic signed [63:0] prod_s1 [4];
	logic signed [64:0] pair_s2 [2];
	logic signed [65:0] sum_s3;
	logic        [31:0] res_s4;
	logic               sat_s4;
	logic signed [49:0] shifted;

	// Stage 1: one 32x32 signed product per column.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c] <= $signed(row[c]) * $signed(vec[c]);
			end
		end
	end

	// Stage 2: pairwise sums.
	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2[0] <= 65'(prod_s1[0]) + 65'(prod_s1[1]);
			pair_s2[1] <= 65'(prod_s1[2]) + 65'(prod_s1[3]);
		end
	end

	// Stage 3: total sum plus half an LSB for round half up.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= 66'(pair_s2[0]) + 66'(pair_s2[1]) + 66'sd32768;
		end
	end

	// Stage 4: drop the 16 fraction bits and clamp to 32 bits.
	assign shifted = 50'(sum_s3 >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			if (shifted > 50'sh7FFF_FFFF) begin
				res_s4 <= 32'h7FFF_FFFF;
				sat_s4 <= 1'b1;
			end else if (shifted < -50'sh8000_0000) begin
				res_s4 <= 32'h8000_0000;
				sat_s4 <= 1'b1;
			end else begin
				res_s4 <= shifted[31:0];
				sat_s4 <= 1'b0;
			end
		end
	end

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

FILE: sv/hvt_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on hvt_pkg. DIV_BITS register stages, advanced by en.
module hvt_div import hvt_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [31:0]         divisor,
	output logic [DIV_BITS-1:0] quotient
);

	logic [31:0]         rem_s [DIV_BITS];
	logic [DIV_BITS-1:0] num_s [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];
	logic [31:0]         den_s [DIV_BITS];

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
		logic [31:0]         rem_in;
		logic [DIV_BITS-1:0] num_in;
		logic [DIV_BITS-1:0] quo_in;
		logic [31:0]         den_in;
		logic [32:0]         trial;
		logic [32:0]         diff;
		logic                ge;

		// First stage starts from a zero remainder.
		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = dividend;
			assign quo_in = '0;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign num_in = num_s[j-1];
			assign quo_in = quo_s[j-1];
			assign den_in = den_s[j-1];
		end

		// Bring down the next dividend bit and try a subtract.
		assign trial = {rem_in, num_in[DIV_BITS-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? diff[31:0] : trial[31:0];
				num_s[j] <= {num_in[DIV_BITS-2:0], 1'b0};
				quo_s[j] <= {quo_in[DIV_BITS-2:0], ge};
				den_s[j] <= den_in;
			end
		end
	end

	assign quotient = quo_s[DIV_BITS-1];

endmodule

FILE: sv/hvt_checker.sv
// Port-level checker for the homogeneous vertex transform core, bound to it.
// Depends on hvt_pkg and homogeneous_vertex_transform_core_defines.svh.
`include "homogeneous_vertex_transform_core_defines.svh"

module hvt_checker import hvt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] in_x,
	input logic [31:0] in_y,
	input logic [31:0] in_z,
	input logic [31:0] in_w,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [31:0] out_z,
	input logic [31:0] out_w,
	input logic        divided,
	input logic        saturated,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic [63:0] cfg_data
);

	// A held result beat keeps its valid, out_x, out_w and divided.
	`HVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_w) && $stable(divided), "result beat changed while stalled")

	// The input side stalls exactly when a waiting result is held back.
	`HVT_ASSERT_NOW(a_stall_link, 1'b1, in_stall == (out_valid && out_stall), "input stall does not follow output backpressure")

	// A divided result never has w of zero or one.
	`HVT_ASSERT_NOW(a_div_w, out_valid && divided, out_w != 32'd0 && out_w != Q_ONE, "divide flagged with w of zero or one")

	// An undivided result always has w of zero or one.
	`HVT_ASSERT_NOW(a_undiv_w, out_valid && !divided, out_w == 32'd0 || out_w == Q_ONE, "divide skipped with w other than zero or one")

endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (.*);

FILE: tb/homogeneous_vertex_transform_checker.sv
// Scoreboard for the homogeneous vertex transform core: follows the matrix
// writes, predicts every result from the accepted vertices, and compares.
// Depends on hvt_pkg for the register indexes and the reset matrix.
module homogeneous_vertex_transform_checker import hvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] in_x,
	input  logic [31:0] in_y,
	input  logic [31:0] in_z,
	input  logic [31:0] in_w,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] out_x,
	input  logic [31:0] out_y,
	input  logic [31:0] out_z,
	input  logic [31:0] out_w,
	input  logic        divided,
	input  logic        saturated,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          divide_hits,
	output int          clamp_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic        div;
		logic        sat;
	} vertex_t;

	logic [7:0][63:0] matrix;
	vertex_t          expected_vertices[$];

	// Clamp a wide signed value to the 32-bit range, flagging any clamp.
	function automatic logic [31:0] clamp_q16(input logic signed [71:0] v,
		inout logic sat);
		if (v > 72'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -72'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Matrix times original vertex, rounded half up, then the perspective divide.
	function automatic vertex_t transform_vertex(input logic [7:0][63:0] m,
		input logic [3:0][31:0] v);
		vertex_t                 res;
		logic [3:0][31:0]        row;
		logic signed [71:0]      acc;
		logic signed [71:0]      quo;
		longint                  prod;
		longint                  num;
		logic [31:0]             coef;
		logic                    sat;
		sat = 1'b0;
		for (int r = 0; r < 4; r++) begin
			acc = '0;
			for (int c = 0; c < 4; c++) begin
				coef = m[r * 2 + c / 2][(c % 2) * 32 +: 32];
				prod = longint'($signed(coef)) * longint'($signed(v[c]));
				acc += 72'(prod);
			end
			acc = (acc + 72'sd32768) >>> 16;
			row[r] = clamp_q16(acc, sat);
		end
		res.div = (row[3] != 32'd0) && (row[3] != Q_ONE);
		if (res.div) begin
			for (int r = 0; r < 3; r++) begin
				num = longint'($signed(row[r])) * 64'sd65536;
				quo = 72'(num / longint'($signed(row[3])));
				row[r] = clamp_q16(quo, sat);
			end
		end
		res.x = row[0];
		res.y = row[1];
		res.z = row[2];
		res.w = row[3];
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Mirror of the matrix registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				matrix[i] <= (i == 0 || i == 5) ? DIAG_LO :
					(i == 2 || i == 7) ? DIAG_HI : 64'd0;
		end else if (cfg_we) begin
			matrix[cfg_index] <= cfg_data;
		end
	end

	initial begin
		fail_count = 0;
		checked = 0;
		divide_hits = 0;
		clamp_hits = 0;
	end

	assign pending = expected_vertices.size();

	// Predict on each accepted input beat, compare on each output beat.
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && in_valid && !in_stall)
			expected_vertices.push_back(transform_vertex(matrix, {in_w, in_z, in_y, in_x}));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vertices.size() == 0) begin
				$display("%0t: output beat with no vertex outstanding", $realtime);
				fail_count++;
			end else begin
				want = expected_vertices.pop_front();
				checked++;
				if (want.div)
					divide_hits++;
				if (want.sat)
					clamp_hits++;
				if (out_x !== want.x)
					report_mismatch("out_x", out_x, want.x);
				if (out_y !== want.y)
					report_mismatch("out_y", out_y, want.y);
				if (out_z !== want.z)
					report_mismatch("out_z", out_z, want.z);
				if (out_w !== want.w)
					report_mismatch("out_w", out_w, want.w);
				if (divided !== want.div)
					report_mismatch("divided", 32'(divided), 32'(want.div));
				if (saturated !== want.sat)
					report_mismatch("saturated", 32'(saturated), 32'(want.sat));
			end
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the vertex transform testbench: clock, reset, matrix settings,
// vertex stimulus with bursts and stalls, watchdog and verdict.
// Depends on hvt_pkg, the core and homogeneous_vertex_transform_checker.
module testbench import hvt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS = 205;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] in_x;
	logic [31:0] in_y;
	logic [31:0] in_z;
	logic [31:0] in_w;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic [31:0] out_w;
	logic        divided;
	logic        saturated;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	int          checked;
	int          divide_hits;
	int          clamp_hits;
	int          burst_left;
	int          stall_mode;
	int          idle_cycles;
	int          settings_used;

	homogeneous_vertex_transform_core uut (.*);

	homogeneous_vertex_transform_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stall pattern: free running, random, or long holds.
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 35);
			default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
		endcase
	end

	// Watchdog on cycles where no beat and no register write happens.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout with %0d results outstanding", pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Matrix entry by kind: small, full range, or an extreme.
	function automatic logic [31:0] pick_entry(input int kind);
		case (kind)
			0: return 32'($signed($urandom_range(0, 262144)) - 131072);
			1: return $urandom();
			default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	// Vertex component: small values keep most sums in range.
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			3: return Q_ONE;
			default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	task automatic write_matrix(input logic [7:0][63:0] m);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= m[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One vertex beat; afterwards a gap may open between bursts.
	task automatic send_vertex(input logic [31:0] x, y, z, w);
		in_valid <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		in_w <= w;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [7:0][63:0] m;
		int               kind;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_x <= '0;
		in_y <= '0;
		in_z <= '0;
		in_w <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROW0_COLS01;
		cfg_data <= '0;
		stall_mode = 0;
		burst_left = 0;
		idle_cycles = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed vertices under the reset identity matrix.
		send_vertex(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, Q_ONE);
		send_vertex(32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0000_0000);
		send_vertex(32'h0003_0000, 32'hfff0_0000, 32'h0005_0000, 32'h0002_0000);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
		send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_0000);
		send_vertex(32'h0000_8000, 32'hffff_8000, 32'h0001_8000, 32'h0000_8000);
		end_stream();
		wait_drained();

		// Directed: all entries at the extremes, forcing dot product clamps.
		for (int i = 0; i < NUM_REGS; i++)
			m[i] = 64'h7fff_ffff_7fff_ffff;
		write_matrix(m);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		end_stream();
		wait_drained();
		for (int i = 0; i < NUM_REGS; i++)
			m[i] = 64'h8000_0000_8000_0000;
		write_matrix(m);
		send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vertex(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		end_stream();
		wait_drained();

		// Random phases, each under a new matrix.
		for (int ph = 0; ph < 8; ph++) begin
			kind = ph % 3;
			for (int i = 0; i < NUM_REGS; i++)
				m[i] = {pick_entry(kind), pick_entry(kind)};
			// Perspective style: w row picks up z, giving frequent divides.
			if (ph == 3)
				m[REG_ROW3_COLS01] = 64'd0;
			if (ph == 3)
				m[REG_ROW3_COLS23] = 64'h0000_0000_0001_0000;
			if (ph == 6)
				m = '0;
			write_matrix(m);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_vertex(pick_comp(), pick_comp(), pick_comp(),
					$urandom_range(0, 3) == 0 ? Q_ONE : pick_comp());
			end_stream();
			wait_drained();
		end

		$display("Checked %0d vertices across %0d matrix settings", checked, settings_used);
		$display("%0d took the divide, %0d were clamped", divide_hits, clamp_hits);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
